@@ rtl/core/ecsl_pkg.sv @@
// Shared types, codes and helpers for the event code slot logic.
// Pulled in by ecsl_cell and event_code_slot_logic; no dependencies.
package ecsl_pkg;

	// Item operations carried on the input channel
	typedef enum logic [1:0] {
		OP_EVENT  = 2'd0,
		OP_ACCEPT = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// Per-term fold operators
	typedef enum logic [1:0] {
		FOLD_OR     = 2'd0,
		FOLD_AND    = 2'd1,
		FOLD_OR_NOT = 2'd2,
		FOLD_AND_N  = 2'd3
	} fold_op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BEAM_COUNT  = 3'd0,
		REG_BEAM_CODES  = 3'd1,
		REG_BEAM_OPS    = 3'd2,
		REG_LASER_COUNT = 3'd3,
		REG_LASER_CODES = 3'd4,
		REG_LASER_OPS   = 3'd5
	} reg_idx_t;

	// Image kinds reported on an accept
	localparam logic [1:0] KIND_LASER_OFF = 2'd0;
	localparam logic [1:0] KIND_LASER_ONLY = 2'd1;
	localparam logic [1:0] KIND_BOTH_ON = 2'd2;

	localparam int unsigned CODES_PER_REG = 4;
	localparam int unsigned IN_SLOT_W = 5;

	typedef struct packed {
		logic [1:0] op;
		logic [IN_SLOT_W-1:0] slot;
		logic [7:0] ev_code;
	} in_word_t;

	typedef struct packed {
		logic beam_on;
		logic laser_on;
		logic [1:0] image_kind;
	} out_word_t;

	// Control travelling down the chain beside the slot index
	typedef struct packed {
		logic vld;
		op_t op;
		logic [7:0] code;
		logic beam_v;
		logic laser_v;
	} item_ctl_t;

	// Per-cell view of the term configuration
	typedef struct packed {
		logic use_b;
		logic [7:0] code_b;
		fold_op_t op_b;
		logic use_l;
		logic [7:0] code_l;
		fold_op_t op_l;
	} term_cfg_t;

	// One step of the fold
	function automatic logic fold_step(input logic v, input logic m, input fold_op_t fop);
		logic r;
		unique case (fop)
			FOLD_OR: r = v | m;
			FOLD_AND: r = v & m;
			FOLD_OR_NOT: r = v | ~m;
			FOLD_AND_N: r = v & ~m;
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/event_code_slot_logic.sv @@
// Top level of the event code slot logic: configuration registers, input
// stage, chain of term cells and output register. Depends on ecsl_pkg, ecsl_cell.
//
// Use:
//   Input channel (in_valid/in_ready/in_data) takes one word per cycle when
//   in_ready is high: an event code marking a slot in every matching term,
//   an accept that folds and clears a slot's marks, or a clear of all marks.
//   Output channel (out_valid/out_ready/out_data) carries beam_on, laser_on
//   and image_kind, one word for each accept; other words give none.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   registers 0..5; it is always ready and indexes above 5 are dropped.
//   Write configuration only while the block is empty.
// Pipeline and throughput:
//   One word per cycle while the chain advances. An accept passes the
//   register in each term cell and then the output register before it
//   reaches out_valid. The cell chain advances unless a result waits.
// Reset: clears all marks, empties the chain and loads counts of one, codes
//   and operators of zero.
// Stall:
//   While a result waits with out_ready low the whole chain holds and
//   in_ready drops; it picks up again in the cycle the result is taken.
module event_code_slot_logic import ecsl_pkg::*; #(
	parameter int MAX_TERMS = 4,
	parameter int SLOTS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_word_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LIMIT = (MAX_TERMS < CODES_PER_REG) ? MAX_TERMS : CODES_PER_REG;
	localparam int SLOT_VALS = 2 ** IN_SLOT_W;

	logic [2:0] beam_count_q;
	logic [31:0] beam_codes_q;
	logic [7:0] beam_ops_q;
	logic [2:0] laser_count_q;
	logic [31:0] laser_codes_q;
	logic [7:0] laser_ops_q;

	logic [2:0] n_beam;
	logic [2:0] n_laser;
	logic adv;
	logic out_valid_q;
	out_word_t out_q;

	logic [SLOT_W-1:0] slot_lut [SLOT_VALS];
	item_ctl_t ctl_chain [MAX_TERMS+1];
	logic [SLOT_W-1:0] slot_chain [MAX_TERMS+1];
	term_cfg_t cell_cfg [MAX_TERMS];

	// Take configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_count_q <= 3'd1;
			beam_codes_q <= '0;
			beam_ops_q <= '0;
			laser_count_q <= 3'd1;
			laser_codes_q <= '0;
			laser_ops_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BEAM_COUNT: beam_count_q <= cfg_data[2:0];
				REG_BEAM_CODES: beam_codes_q <= cfg_data;
				REG_BEAM_OPS: beam_ops_q <= cfg_data[7:0];
				REG_LASER_COUNT: laser_count_q <= cfg_data[2:0];
				REG_LASER_CODES: laser_codes_q <= cfg_data;
				REG_LASER_OPS: laser_ops_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Limit term counts to one..LIMIT
	always_comb begin
		priority if (beam_count_q == 3'd0) begin
			n_beam = 3'd1;
		end else if (beam_count_q > 3'(LIMIT)) begin
			n_beam = 3'(LIMIT);
		end else begin
			n_beam = beam_count_q;
		end
		priority if (laser_count_q == 3'd0) begin
			n_laser = 3'd1;
		end else if (laser_count_q > 3'(LIMIT)) begin
			n_laser = 3'(LIMIT);
		end else begin
			n_laser = laser_count_q;
		end
	end

	// Slot reduction table and per-cell term view
	genvar gi;
	generate
		for (gi = 0; gi < SLOT_VALS; gi++) begin : g_lut
			assign slot_lut[gi] = SLOT_W'(gi % SLOTS);
		end
		for (gi = 0; gi < MAX_TERMS; gi++) begin : g_cfg
			if (gi < CODES_PER_REG) begin : g_live
				assign cell_cfg[gi].use_b = n_beam > 3'(gi);
				assign cell_cfg[gi].code_b = beam_codes_q[8*gi +: 8];
				assign cell_cfg[gi].op_b = fold_op_t'(beam_ops_q[2*gi +: 2]);
				assign cell_cfg[gi].use_l = n_laser > 3'(gi);
				assign cell_cfg[gi].code_l = laser_codes_q[8*gi +: 8];
				assign cell_cfg[gi].op_l = fold_op_t'(laser_ops_q[2*gi +: 2]);
			end else begin : g_idle
				assign cell_cfg[gi] = '0;
			end
		end
	endgenerate

	// Chain advances unless a result waits
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	// Head of the chain: fold seeds from term 0's operator
	always_comb begin
		ctl_chain[0].vld = in_valid;
		ctl_chain[0].op = op_t'(in_data.op);
		ctl_chain[0].code = in_data.ev_code;
		ctl_chain[0].beam_v = beam_ops_q[0];
		ctl_chain[0].laser_v = laser_ops_q[0];
		slot_chain[0] = slot_lut[in_data.slot];
	end

	generate
		for (gi = 0; gi < MAX_TERMS; gi++) begin : g_cell
			ecsl_cell #(
				.SLOTS(SLOTS),
				.SLOT_W(SLOT_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.adv(adv),
				.cfg(cell_cfg[gi]),
				.ctl_in(ctl_chain[gi]),
				.slot_in(slot_chain[gi]),
				.ctl_s1(ctl_chain[gi+1]),
				.slot_s1(slot_chain[gi+1])
			);
		end
	endgenerate

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_chain[MAX_TERMS].vld && ctl_chain[MAX_TERMS].op == OP_ACCEPT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.beam_on <= ctl_chain[MAX_TERMS].beam_v;
			out_q.laser_on <= ctl_chain[MAX_TERMS].laser_v;
			priority if (!ctl_chain[MAX_TERMS].laser_v) begin
				out_q.image_kind <= KIND_LASER_OFF;
			end else if (!ctl_chain[MAX_TERMS].beam_v) begin
				out_q.image_kind <= KIND_LASER_ONLY;
			end else begin
				out_q.image_kind <= KIND_BOTH_ON;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ rtl/core/ecsl_cell.sv @@
// One term cell: holds the beam and laser marks of one term and applies
// one fold step to the word passing through. Depends on ecsl_pkg.
module ecsl_cell import ecsl_pkg::*; #(
	parameter int SLOTS = 32,
	parameter int SLOT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  term_cfg_t cfg,
	input  item_ctl_t ctl_in,
	input  logic [SLOT_W-1:0] slot_in,
	output item_ctl_t ctl_s1,
	output logic [SLOT_W-1:0] slot_s1
);

	logic [SLOTS-1:0] beam_q;
	logic [SLOTS-1:0] laser_q;
	logic [SLOTS-1:0] bit_sel;
	logic m_b;
	logic m_l;
	item_ctl_t ctl_nxt;

	// Fold this term's marks into the travelling word
	always_comb begin
		bit_sel = '0;
		bit_sel[slot_in] = 1'b1;
		m_b = beam_q[slot_in];
		m_l = laser_q[slot_in];
		ctl_nxt = ctl_in;
		if (cfg.use_b) begin
			ctl_nxt.beam_v = fold_step(ctl_in.beam_v, m_b, cfg.op_b);
		end
		if (cfg.use_l) begin
			ctl_nxt.laser_v = fold_step(ctl_in.laser_v, m_l, cfg.op_l);
		end
	end

	// Hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= slot_in;
		end
	end

	// Update marks in item order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
			laser_q <= '0;
		end else if (adv && ctl_in.vld) begin
			unique case (ctl_in.op)
				OP_EVENT: begin
					if (cfg.use_b && cfg.code_b == ctl_in.code) begin
						beam_q <= beam_q | bit_sel;
					end
					if (cfg.use_l && cfg.code_l == ctl_in.code) begin
						laser_q <= laser_q | bit_sel;
					end
				end
				OP_ACCEPT: begin
					beam_q <= beam_q & ~bit_sel;
					laser_q <= laser_q & ~bit_sel;
				end
				OP_CLEAR: begin
					beam_q <= '0;
					laser_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ bench/tb_event_code_slot_logic.sv @@
// Self-checking bench for event_code_slot_logic: tracks the beam and laser mark tables,
// predicts every accept word and compares it against the output channel.
// Depends on ecsl_pkg and the event_code_slot_logic RTL only.
module tb_event_code_slot_logic import ecsl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_TERMS = 4;
	localparam int SLOTS = 32;
	localparam int SETTLE_CYCLES = MAX_TERMS + 6;
	localparam int ITEMS_PER_PHASE = 117;
	localparam int PHASES = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	// Mirror of the term tables; predicts the word each accept produces
	class slot_fold_tracker;
		logic [2:0] beam_count, laser_count;
		logic [31:0] beam_codes, laser_codes;
		logic [7:0] beam_ops, laser_ops;
		logic [SLOTS-1:0] beam_marks [MAX_TERMS];
		logic [SLOTS-1:0] laser_marks [MAX_TERMS];
		out_word_t awaited_reports [$];
		int unsigned errors;

		function new();
			beam_count = 3'd1;
			laser_count = 3'd1;
			beam_codes = '0;
			laser_codes = '0;
			beam_ops = '0;
			laser_ops = '0;
			clear_marks();
			errors = 0;
		endfunction

		function void clear_marks();
			for (int i = 0; i < MAX_TERMS; i++) begin
				beam_marks[i] = '0;
				laser_marks[i] = '0;
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_BEAM_COUNT: beam_count = data[2:0];
				REG_BEAM_CODES: beam_codes = data;
				REG_BEAM_OPS: beam_ops = data[7:0];
				REG_LASER_COUNT: laser_count = data[2:0];
				REG_LASER_CODES: laser_codes = data;
				REG_LASER_OPS: laser_ops = data[7:0];
				default: ;
			endcase
		endfunction

		// Zero counts as one term; clamp to the table and register size
		function int active_terms(logic [2:0] count);
			int n;
			n = int'(count);
			if (n < 1) n = 1;
			if (n > MAX_TERMS) n = MAX_TERMS;
			if (n > CODES_PER_REG) n = CODES_PER_REG;
			return n;
		endfunction

		// Fold one slot's marks in term order; start true on an AND form
		function logic fold_slot(logic [SLOTS-1:0] marks [MAX_TERMS], logic [2:0] count,
				logic [7:0] ops, int unsigned slot);
			logic v;
			logic m;
			fold_op_t fop;
			v = ops[0];
			for (int i = 0; i < active_terms(count); i++) begin
				m = marks[i][slot];
				fop = fold_op_t'(ops[2*i +: 2]);
				case (fop)
					FOLD_OR: v = v | m;
					FOLD_AND: v = v & m;
					FOLD_OR_NOT: v = v | ~m;
					default: v = v & ~m;
				endcase
			end
			return v;
		endfunction

		function void take_item(in_word_t w);
			int unsigned slot;
			out_word_t rep;
			slot = w.slot % SLOTS;
			case (w.op)
				OP_EVENT: begin
					for (int i = 0; i < active_terms(beam_count); i++)
						if (beam_codes[8*i +: 8] == w.ev_code) beam_marks[i][slot] = 1'b1;
					for (int i = 0; i < active_terms(laser_count); i++)
						if (laser_codes[8*i +: 8] == w.ev_code) laser_marks[i][slot] = 1'b1;
				end
				OP_ACCEPT: begin
					rep.beam_on = fold_slot(beam_marks, beam_count, beam_ops, slot);
					rep.laser_on = fold_slot(laser_marks, laser_count, laser_ops, slot);
					if (!rep.laser_on) rep.image_kind = KIND_LASER_OFF;
					else if (!rep.beam_on) rep.image_kind = KIND_LASER_ONLY;
					else rep.image_kind = KIND_BOTH_ON;
					awaited_reports.push_back(rep);
					// drop the slot bit in every term, in use or not
					for (int i = 0; i < MAX_TERMS; i++) begin
						beam_marks[i][slot] = 1'b0;
						laser_marks[i][slot] = 1'b0;
					end
				end
				OP_CLEAR: clear_marks();
				default: ;
			endcase
		endfunction

		function void check_report(out_word_t got);
			out_word_t want;
			if (awaited_reports.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			want = awaited_reports.pop_front();
			if (got.beam_on !== want.beam_on) begin
				$error("beam_on: expected %0d, got %0d", want.beam_on, got.beam_on);
				errors++;
			end
			if (got.laser_on !== want.laser_on) begin
				$error("laser_on: expected %0d, got %0d", want.laser_on, got.laser_on);
				errors++;
			end
			if (got.image_kind !== want.image_kind) begin
				$error("image_kind: expected %0d, got %0d", want.image_kind, got.image_kind);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_data;
	logic out_valid;
	logic out_ready;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	slot_fold_tracker tracker = new();
	int send_idle_pct = 36;
	int recv_idle_pct = 63;
	int hold_off_cycles = 0;
	logic [7:0] term_codes [8];
	logic [4:0] hot_slots [4];

	event_code_slot_logic #(
		.MAX_TERMS(MAX_TERMS),
		.SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drive the receiver side: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check every result word taken from the output channel
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && out_ready) tracker.check_report(out_data);
	end

	function automatic int sender_gap();
		int g;
		g = 0;
		while (g < 12 && $urandom_range(99) < send_idle_pct) g++;
		return g;
	endfunction

	function automatic in_word_t make_word(logic [1:0] op, logic [4:0] slot, logic [7:0] code);
		in_word_t w;
		w.op = op;
		w.slot = slot;
		w.ev_code = code;
		return w;
	endfunction

	// Offer one word, holding it until taken
	task automatic send_word(input in_word_t w);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		tracker.take_item(w);
	endtask

	// Stop offering, wait for every awaited word, then let the chain empty
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic release_cfg();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pick one register setting per phase: minimum, maximum, then random ones
	task automatic configure_phase(input int k);
		logic [7:0] pool [6];
		logic [2:0] bc, lc;
		logic [31:0] bcodes, lcodes;
		logic [7:0] bops, lops;
		logic [28:0] pad;
		foreach (pool[j]) pool[j] = 8'($urandom_range(255));
		for (int j = 0; j < 4; j++) begin
			bcodes[8*j +: 8] = pool[$urandom_range(5)];
			lcodes[8*j +: 8] = pool[$urandom_range(5)];
		end
		pad = 29'($urandom());
		bc = 3'($urandom_range(7));
		lc = 3'($urandom_range(7));
		bops = 8'($urandom());
		lops = 8'($urandom());
		case (k % 4)
			0: begin
				bc = 3'd0;
				lc = 3'd1;
				bops = 8'h00;
				lops = 8'h00;
				lcodes = 32'h0000_0000;
				pad = '0;
			end
			1: begin
				bc = 3'd7;
				lc = 3'd4;
				bops = 8'hff;
				lops = 8'hff;
				bcodes = 32'hffff_ffff;
				pad = '1;
			end
			default: ;
		endcase
		write_cfg(REG_BEAM_COUNT, {pad, bc});
		write_cfg(REG_BEAM_CODES, bcodes);
		write_cfg(REG_BEAM_OPS, {pad[23:0], bops});
		write_cfg(REG_LASER_COUNT, {~pad, lc});
		write_cfg(REG_LASER_CODES, lcodes);
		write_cfg(REG_LASER_OPS, {~pad[23:0], lops});
		write_cfg(REG_SPARE_A, $urandom());
		write_cfg(REG_SPARE_B, $urandom());
		release_cfg();
		for (int j = 0; j < 4; j++) begin
			term_codes[j] = bcodes[8*j +: 8];
			term_codes[j+4] = lcodes[8*j +: 8];
			hot_slots[j] = 5'($urandom_range(31));
		end
		if (k % 3 == 0) begin
			hot_slots[0] = 5'd0;
			hot_slots[1] = 5'd31;
		end
	endtask

	// Mostly events on four busy slots with matching codes, then accepts; some clears and spare ops
	function automatic in_word_t random_word();
		int r;
		logic [1:0] op;
		logic [4:0] slot;
		logic [7:0] code;
		r = $urandom_range(99);
		if (r < 60) op = OP_EVENT;
		else if (r < 93) op = OP_ACCEPT;
		else if (r < 96) op = OP_CLEAR;
		else op = OP_SPARE;
		if ($urandom_range(99) < 70) slot = hot_slots[$urandom_range(3)];
		else slot = 5'($urandom_range(31));
		if ($urandom_range(99) < 75) code = term_codes[$urandom_range(7)];
		else code = 8'($urandom_range(255));
		return make_word(op, slot, code);
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: one OR term per table, code zero
		send_word(make_word(OP_EVENT, 5'd0, 8'h00));
		send_word(make_word(OP_ACCEPT, 5'd0, 8'hff));
		send_word(make_word(OP_ACCEPT, 5'd0, 8'h00));
		send_word(make_word(OP_EVENT, 5'd31, 8'hff));
		send_word(make_word(OP_SPARE, 5'd31, 8'h00));
		send_word(make_word(OP_ACCEPT, 5'd31, 8'h00));
		send_word(make_word(OP_EVENT, 5'd31, 8'h00));
		send_word(make_word(OP_CLEAR, 5'd31, 8'h00));
		send_word(make_word(OP_ACCEPT, 5'd31, 8'h00));
		drain_and_settle();

		// Four beam terms with every operator; laser count above the table size
		write_cfg(REG_BEAM_COUNT, 32'hffff_fffc);
		write_cfg(REG_BEAM_CODES, 32'hff33_2211);
		write_cfg(REG_BEAM_OPS, {24'h0, FOLD_OR, FOLD_OR_NOT, FOLD_AND_N, FOLD_AND});
		write_cfg(REG_LASER_COUNT, 32'h0000_0007);
		write_cfg(REG_LASER_CODES, 32'h8844_2200);
		write_cfg(REG_LASER_OPS, {24'h0, FOLD_AND_N, FOLD_AND, FOLD_OR_NOT, FOLD_OR});
		release_cfg();
		send_word(make_word(OP_EVENT, 5'd3, 8'h11));
		send_word(make_word(OP_EVENT, 5'd3, 8'h22));
		send_word(make_word(OP_ACCEPT, 5'd3, 8'h00));
		send_word(make_word(OP_EVENT, 5'd7, 8'h00));
		send_word(make_word(OP_EVENT, 5'd7, 8'h88));
		send_word(make_word(OP_ACCEPT, 5'd7, 8'h00));
		send_word(make_word(OP_EVENT, 5'd16, 8'h44));
		send_word(make_word(OP_ACCEPT, 5'd16, 8'h00));
		send_word(make_word(OP_ACCEPT, 5'd1, 8'h00));
		send_word(make_word(OP_EVENT, 5'd31, 8'hff));
		send_word(make_word(OP_SPARE, 5'd31, 8'hff));
		send_word(make_word(OP_ACCEPT, 5'd31, 8'hff));

		// Random phases: sender-light, receiver-light, then no idling at all
		for (int k = 0; k < PHASES; k++) begin
			drain_and_settle();
			if (k < 4) begin
				send_idle_pct = 36;
				recv_idle_pct = 63;
			end else if (k < 8) begin
				send_idle_pct = 63;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure_phase(k);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// hold the receiver off so the chain fills and stalls the input
				if (k == 2 && i == 20) hold_off_cycles = LONG_HOLD_CYCLES;
				if (k == 9 && i == 30) hold_off_cycles = LONG_HOLD_CYCLES;
				// pause the sender until every word is back
				if (k == 5 && i == 60) drain_and_settle();
				send_word(random_word());
			end
		end

		drain_and_settle();
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
